FILE: design/ckx_pkg.sv
// Shared types, constants and helper functions for the canonical k-mer extractor.
package ckx_pkg;

   localparam int unsigned MAX_KMER_LEN = 32;
   localparam int unsigned BASE_SLOTS   = 32;
   localparam int unsigned KMER_W       = 2 * BASE_SLOTS;
   localparam int unsigned LEN_W        = 6;
   localparam int unsigned CHAR_W       = 8;
   localparam int unsigned ID_W         = 32;

   localparam logic [LEN_W-1:0] KMER_LEN_RESET = 6'd18;
   localparam logic [1:0]       BASE_MASK      = 2'b11;

   localparam logic [1:0] CODE_A = 2'd0;
   localparam logic [1:0] CODE_C = 2'd1;
   localparam logic [1:0] CODE_G = 2'd2;
   localparam logic [1:0] CODE_T = 2'd3;

   typedef logic [KMER_W-1:0] kmer_type;

   typedef struct packed {
      logic                  valid;
      logic [1:0]            code;
   } base_code_type;

   typedef struct packed {
      logic [LEN_W-1:0]      eff_len;
      kmer_type              mask;
      logic [BASE_SLOTS-1:0] top_sel;
      logic                  clear;
   } ckx_cfg_type;

   function automatic base_code_type encode_base(logic [CHAR_W-1:0] c);
      base_code_type r;
      r.valid = 1'b1;
      case (c)
         "A", "a": r.code = CODE_A;
         "C", "c": r.code = CODE_C;
         "G", "g": r.code = CODE_G;
         "T", "t": r.code = CODE_T;
         default: begin
            r.valid = 1'b0;
            r.code  = CODE_A;
         end
      endcase
      return r;
   endfunction

   // Zero acts as one, anything past the maximum acts as the maximum.
   function automatic logic [LEN_W-1:0] clamp_len(logic [LEN_W-1:0] v);
      logic [LEN_W-1:0] k;
      k = v;
      if (k == '0)
         k = LEN_W'(1);
      else if (k > LEN_W'(MAX_KMER_LEN))
         k = LEN_W'(MAX_KMER_LEN);
      return k;
   endfunction

   function automatic kmer_type len_mask(logic [LEN_W-1:0] k);
      kmer_type m;
      for (int i = 0; i < BASE_SLOTS; i++)
         m[2*i +: 2] = (LEN_W'(i) < k) ? 2'b11 : 2'b00;
      return m;
   endfunction

   // One-hot marker of the base slot where the complement enters.
   function automatic logic [BASE_SLOTS-1:0] top_slot(logic [LEN_W-1:0] k);
      logic [BASE_SLOTS-1:0] t;
      for (int i = 0; i < BASE_SLOTS; i++)
         t[i] = (LEN_W'(i) == (k - LEN_W'(1)));
      return t;
   endfunction

endpackage

FILE: design/ckx_if.sv
// Channel interfaces: character requests, k-mer responses and the length register write.
interface ckx_req_if;
   logic                      valid;
   logic                      ready;
   logic [ckx_pkg::CHAR_W-1:0] base_char;
   logic                      first_of_sequence;
   logic [ckx_pkg::ID_W-1:0]  seq_id;

   modport source (output valid, output base_char, output first_of_sequence,
                   output seq_id, input ready);
   modport sink   (input valid, input base_char, input first_of_sequence,
                   input seq_id, output ready);
endinterface

interface ckx_rsp_if;
   logic                     valid;
   logic                     ready;
   logic [ckx_pkg::KMER_W-1:0] canonical_kmer;
   logic [ckx_pkg::ID_W-1:0] kmer_seq_id;

   modport source (output valid, output canonical_kmer, output kmer_seq_id, input ready);
   modport sink   (input valid, input canonical_kmer, input kmer_seq_id, output ready);
endinterface

interface ckx_csr_if;
   logic                      valid;
   logic                      ready;
   logic [ckx_pkg::LEN_W-1:0] kmer_length;

   modport source (output valid, output kmer_length, input ready);
   modport sink   (input valid, input kmer_length, output ready);
endinterface

FILE: design/ckx_cfg.sv
// Length register: holds the clamped k-mer length and the mask and entry slot derived from it.
module ckx_cfg (
   input  logic                 clock,
   input  logic                 reset,
   ckx_csr_if.sink              csr_chan,
   output ckx_pkg::ckx_cfg_type cfg
);
   import ckx_pkg::*;

   logic [LEN_W-1:0]      eff_len_ff, eff_len_in;
   kmer_type              mask_ff, mask_in;
   logic [BASE_SLOTS-1:0] top_sel_ff, top_sel_in;
   logic                  wr_en;

   assign csr_chan.ready = 1'b1;
   assign wr_en          = csr_chan.valid & csr_chan.ready;

   always_comb begin
      eff_len_in = eff_len_ff;
      mask_in    = mask_ff;
      top_sel_in = top_sel_ff;
      if (wr_en) begin
         eff_len_in = clamp_len(csr_chan.kmer_length);
         mask_in    = len_mask(clamp_len(csr_chan.kmer_length));
         top_sel_in = top_slot(clamp_len(csr_chan.kmer_length));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eff_len_ff <= clamp_len(KMER_LEN_RESET);
         mask_ff    <= len_mask(clamp_len(KMER_LEN_RESET));
         top_sel_ff <= top_slot(clamp_len(KMER_LEN_RESET));
      end else begin
         eff_len_ff <= eff_len_in;
         mask_ff    <= mask_in;
         top_sel_ff <= top_sel_in;
      end
   end

   assign cfg.eff_len = eff_len_ff;
   assign cfg.mask    = mask_ff;
   assign cfg.top_sel = top_sel_ff;
   assign cfg.clear   = wr_en;

`ifndef SYNTH
   a_len_range: assert property (@(posedge clock) disable iff (reset)
      eff_len_ff != '0 && eff_len_ff <= LEN_W'(MAX_KMER_LEN))
      else $error("clamped k-mer length out of range");
   a_top_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(top_sel_ff) && (top_sel_ff == top_slot(eff_len_ff)))
      else $error("entry slot not one-hot");
`endif

endmodule

FILE: design/ckx_kmer_core.sv
// Forward and reverse-complement k-mer state, run counter and canonical select.
module ckx_kmer_core (
   input  logic                       clock,
   input  logic                       reset,
   input  ckx_pkg::ckx_cfg_type       cfg,
   input  logic                       step,
   input  logic [ckx_pkg::CHAR_W-1:0] base_char,
   input  logic                       first_of_sequence,
   output logic                       emit,
   output ckx_pkg::kmer_type          canonical_kmer
);
   import ckx_pkg::*;

   kmer_type         fwd_ff, fwd_in;
   kmer_type         rev_ff, rev_in;
   logic [LEN_W-1:0] run_ff, run_in;

   kmer_type         fwd_base, rev_base, rev_down, rev_shift;
   logic [LEN_W-1:0] run_base;
   base_code_type    bc;

   always_comb begin
      fwd_base = first_of_sequence ? '0 : fwd_ff;
      rev_base = first_of_sequence ? '0 : rev_ff;
      run_base = first_of_sequence ? '0 : run_ff;
      bc       = encode_base(base_char);
      rev_down = rev_base >> 2;

      // reverse register shifts toward the low end; complement enters at slot k-1
      for (int i = 0; i < BASE_SLOTS; i++) begin
         if (cfg.top_sel[i])
            rev_shift[2*i +: 2] = bc.code ^ BASE_MASK;
         else
            rev_shift[2*i +: 2] = rev_down[2*i +: 2];
      end

      if (bc.valid) begin
         fwd_in = {fwd_base[KMER_W-3:0], bc.code} & cfg.mask;
         rev_in = rev_shift & cfg.mask;
         run_in = (run_base < cfg.eff_len) ? run_base + LEN_W'(1) : cfg.eff_len;
      end else begin
         fwd_in = fwd_base;
         rev_in = rev_base;
         run_in = '0;
      end

      emit           = bc.valid && (run_in >= cfg.eff_len);
      canonical_kmer = (fwd_in < rev_in) ? fwd_in : rev_in;
   end

   always_ff @(posedge clock) begin
      if (reset || cfg.clear) begin
         fwd_ff <= '0;
         rev_ff <= '0;
         run_ff <= '0;
      end else if (step) begin
         fwd_ff <= fwd_in;
         rev_ff <= rev_in;
         run_ff <= run_in;
      end
   end

`ifndef SYNTH
   a_run_sat: assert property (@(posedge clock) disable iff (reset)
      run_ff <= cfg.eff_len)
      else $error("run count above k");
   a_fwd_masked: assert property (@(posedge clock) disable iff (reset)
      (fwd_ff & ~cfg.mask) == '0)
      else $error("forward k-mer has bits above 2k");
   a_rev_masked: assert property (@(posedge clock) disable iff (reset)
      (rev_ff & ~cfg.mask) == '0)
      else $error("reverse k-mer has bits above 2k");
`endif

endmodule

FILE: design/canonical_kmer_extractor.sv
// Top level: input stage, k-mer core and response register of the canonical k-mer extractor.
//
//  channel   dir  handshake          payload
//  req_chan  in   valid/ready        base_char, first_of_sequence, seq_id
//  rsp_chan  out  valid/ready        canonical_kmer, kmer_seq_id
//  csr_chan  in   valid/ready (=1)   kmer_length
//
// One character per cycle sustained unless the response stalls.
// The per-base shift, mask and 64-bit min compare sit between the input register
// and the response register. Synchronous reset clears the k-mer state and sets k to 18.
// A stalled response holds the pipe; the input register still takes a transaction
// whenever it is empty or moving on.
module canonical_kmer_extractor (
   input  logic       clock,
   input  logic       reset,
   ckx_req_if.sink    req_chan,
   ckx_rsp_if.source  rsp_chan,
   ckx_csr_if.sink    csr_chan
);
   import ckx_pkg::*;

   ckx_cfg_type       cfg;

   logic              in_valid_ff, in_valid_in;
   logic [CHAR_W-1:0] in_char_ff;
   logic              in_first_ff;
   logic [ID_W-1:0]   in_id_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   kmer_type          rsp_kmer_ff;
   logic [ID_W-1:0]   rsp_id_ff;

   logic              out_free, advance, req_ready, emit;
   kmer_type          core_kmer;

   ckx_cfg u_cfg (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   ckx_kmer_core u_core (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .step              (advance),
      .base_char         (in_char_ff),
      .first_of_sequence (in_first_ff),
      .emit              (emit),
      .canonical_kmer    (core_kmer)
   );

   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_ready)
         in_valid_in = req_chan.valid;
      rsp_valid_in = rsp_valid_ff;
      if (out_free)
         rsp_valid_in = advance && emit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_chan.valid) begin
         in_char_ff  <= req_chan.base_char;
         in_first_ff <= req_chan.first_of_sequence;
         in_id_ff    <= req_chan.seq_id;
      end
      if (advance && emit) begin
         rsp_kmer_ff <= core_kmer;
         rsp_id_ff   <= in_id_ff;
      end
   end

   assign req_chan.ready          = req_ready;
   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.canonical_kmer = rsp_kmer_ff;
   assign rsp_chan.kmer_seq_id    = rsp_id_ff;

`ifndef SYNTH
   a_rsp_from_core: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(advance && emit))
      else $error("response raised without a completed k-mer");
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !out_free) |=> (in_valid_ff && $stable(in_id_ff)))
      else $error("stalled input transaction lost");
   a_no_step_when_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_chan.ready) |-> !advance)
      else $error("core stepped while response stalled");
`endif

endmodule

FILE: verif/testbench.sv
// Testbench for the canonical k-mer extractor: directed table, random sequences, predictor check.
`timescale 1ns / 100ps

module testbench;
   import ckx_pkg::*;

   localparam int IDLE_LIMIT = 2000;
   localparam int SETTLE_CYCLES = 4;
   localparam int PHASES = 12;
   localparam int PHASE_ITEMS = 140;
   localparam int LONG_HOLD = 100;

   typedef struct packed {
      logic             set_len;
      logic [LEN_W-1:0] len;
      logic [7:0]       ch;
      logic             first;
      logic [ID_W-1:0]  id;
      logic [5:0]       reps;
      logic             typed;
      kmer_type         kmer;
   } stim_row_type;

   typedef struct packed {
      kmer_type        kmer;
      logic [ID_W-1:0] id;
   } kmer_rec_type;

   localparam int DIR_ROWS = 20;

   logic clock;
   logic reset;

   ckx_req_if req_chan ();
   ckx_rsp_if rsp_chan ();
   ckx_csr_if csr_chan ();

   canonical_kmer_extractor u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // predictor state
   logic [LEN_W-1:0] kmer_len_reg;
   kmer_type         fwd_reg;
   kmer_type         rev_reg;
   int unsigned      run_len;

   kmer_rec_type   pending_kmers[$];
   int             fail_count;
   int             idle_cycles;
   bit             no_idle;
   int             hold_off_cycles;
   stim_row_type   directed_rows [DIR_ROWS];

   always #4 clock = ~clock;

   function automatic int unsigned active_k(logic [LEN_W-1:0] v);
      if (v == 0)
         return 1;
      else if (v > MAX_KMER_LEN)
         return MAX_KMER_LEN;
      return v;
   endfunction

   // Shift one character into the k-mer pair; hit is set when a full k-mer is ready.
   function automatic void advance_kmer(input logic [7:0] ch, input logic first,
                                        output logic hit, output kmer_type canon);
      int unsigned k;
      kmer_type    mask;
      logic [1:0]  code;
      logic        good;
      k = active_k(kmer_len_reg);
      mask = (k == 32) ? '1 : (kmer_type'(1) << (2 * k)) - kmer_type'(1);
      hit = 1'b0;
      canon = '0;
      if (first) begin
         fwd_reg = '0;
         rev_reg = '0;
         run_len = 0;
      end
      good = 1'b1;
      case (ch)
         "A", "a": code = CODE_A;
         "C", "c": code = CODE_C;
         "G", "g": code = CODE_G;
         "T", "t": code = CODE_T;
         default: begin
            code = CODE_A;
            good = 1'b0;
         end
      endcase
      if (!good) begin
         run_len = 0;
         return;
      end
      fwd_reg = ((fwd_reg << 2) | kmer_type'(code)) & mask;
      rev_reg = ((kmer_type'(code ^ BASE_MASK) << (2 * (k - 1))) | (rev_reg >> 2)) & mask;
      if (run_len < k)
         run_len++;
      if (run_len >= k) begin
         hit = 1'b1;
         canon = (fwd_reg < rev_reg) ? fwd_reg : rev_reg;
      end
   endfunction

   task automatic send_char(input logic [7:0] ch, input logic first, input logic [ID_W-1:0] id,
                            input logic typed, input kmer_type typed_kmer);
      int       gap;
      logic     hit;
      kmer_type canon;
      gap = no_idle ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid             <= 1'b1;
      req_chan.base_char         <= ch;
      req_chan.first_of_sequence <= first;
      req_chan.seq_id            <= id;
      @(negedge clock);
      while (!req_chan.ready) @(negedge clock);
      @(posedge clock);
      advance_kmer(ch, first, hit, canon);
      if (hit)
         pending_kmers.push_back('{kmer: typed ? typed_kmer : canon, id: id});
   endtask

   // Length writes happen only with the pipe drained.
   task automatic write_length(input logic [LEN_W-1:0] v);
      req_chan.valid <= 1'b0;
      while (pending_kmers.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_chan.valid       <= 1'b1;
      csr_chan.kmer_length <= v;
      @(negedge clock);
      while (!csr_chan.ready) @(negedge clock);
      @(posedge clock);
      csr_chan.valid <= 1'b0;
      kmer_len_reg = v;
      fwd_reg = '0;
      rev_reg = '0;
      run_len = 0;
   endtask

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) ||
          (csr_chan.valid && csr_chan.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
         end
      end
   end

   // response side
   initial begin
      int        stall;
      kmer_type  got_kmer;
      logic [ID_W-1:0] got_id;
      kmer_rec_type want;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 5);
         if (hold_off_cycles != 0) begin
            stall = hold_off_cycles;
            hold_off_cycles = 0;
         end
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         @(negedge clock);
         while (!rsp_chan.valid) @(negedge clock);
         got_kmer = rsp_chan.canonical_kmer;
         got_id   = rsp_chan.kmer_seq_id;
         @(posedge clock);
         if (pending_kmers.size() == 0) begin
            $display("%0t: unexpected transaction kmer=%h id=%h", $time, got_kmer, got_id);
            fail_count++;
         end else begin
            want = pending_kmers.pop_front();
            if (want.kmer !== got_kmer) begin
               $display("%0t: canonical_kmer expected %h actual %h", $time, want.kmer, got_kmer);
               fail_count++;
            end
            if (want.id !== got_id) begin
               $display("%0t: kmer_seq_id expected %h actual %h", $time, want.id, got_id);
               fail_count++;
            end
         end
      end
   end

   // stimulus
   initial begin
      int unsigned k;
      int          sent;
      int          seq_len;
      int          seq_idx;
      int          r;
      logic [7:0]  ch;
      logic        first;
      logic [ID_W-1:0]  id;
      logic [LEN_W-1:0] len;
      logic [LEN_W-1:0] phase_len [8];

      clock = 1'b0;
      reset = 1'b1;
      fail_count = 0;
      idle_cycles = 0;
      no_idle = 1'b0;
      hold_off_cycles = 0;
      req_chan.valid             <= 1'b0;
      req_chan.base_char         <= '0;
      req_chan.first_of_sequence <= 1'b0;
      req_chan.seq_id            <= '0;
      csr_chan.valid             <= 1'b0;
      csr_chan.kmer_length       <= '0;
      kmer_len_reg = KMER_LEN_RESET;
      fwd_reg = '0;
      rev_reg = '0;
      run_len = 0;

      // set_len, len, char, first, id, reps, typed, kmer
      directed_rows = '{
         '{1'b0, 6'd0,  "A",   1'b1, 32'h0000_0000, 6'd18, 1'b1, 64'd0}, // reset length
         '{1'b1, 6'd1,  8'h00, 1'b0, 32'h0,         6'd0,  1'b0, 64'd0},
         '{1'b0, 6'd0,  "A",   1'b1, 32'hFFFF_FFFF, 6'd1,  1'b1, 64'd0},
         '{1'b0, 6'd0,  "T",   1'b0, 32'h0000_0001, 6'd1,  1'b1, 64'd0},
         '{1'b0, 6'd0,  "c",   1'b0, 32'h8000_0000, 6'd1,  1'b1, 64'd1},
         '{1'b0, 6'd0,  "N",   1'b0, 32'h1234_5678, 6'd1,  1'b0, 64'd0},
         '{1'b0, 6'd0,  8'h00, 1'b0, 32'h0,         6'd1,  1'b0, 64'd0},
         '{1'b0, 6'd0,  8'hFF, 1'b0, 32'hFFFF_FFFF, 6'd1,  1'b0, 64'd0},
         '{1'b0, 6'd0,  "C",   1'b0, 32'h5555_AAAA, 6'd1,  1'b1, 64'd1},
         '{1'b1, 6'd2,  8'h00, 1'b0, 32'h0,         6'd0,  1'b0, 64'd0},
         '{1'b0, 6'd0,  "a",   1'b1, 32'h0000_0002, 6'd1,  1'b0, 64'd0},
         '{1'b0, 6'd0,  "C",   1'b0, 32'h0000_0003, 6'd1,  1'b1, 64'd1},
         '{1'b0, 6'd0,  "x",   1'b0, 32'h0000_0004, 6'd1,  1'b0, 64'd0}, // breaks run
         '{1'b0, 6'd0,  "T",   1'b0, 32'h0000_0005, 6'd1,  1'b0, 64'd0},
         '{1'b0, 6'd0,  "t",   1'b0, 32'h0000_0006, 6'd1,  1'b0, 64'd0},
         '{1'b0, 6'd0,  "A",   1'b1, 32'h0000_0007, 6'd1,  1'b0, 64'd0}, // restart mid-run
         '{1'b1, 6'd0,  8'h00, 1'b0, 32'h0,         6'd0,  1'b0, 64'd0}, // zero acts as one
         '{1'b0, 6'd0,  "G",   1'b1, 32'hDEAD_BEEF, 6'd1,  1'b1, 64'd1},
         '{1'b1, 6'd63, 8'h00, 1'b0, 32'h0,         6'd0,  1'b0, 64'd0}, // clamps to max
         '{1'b0, 6'd0,  "g",   1'b1, 32'h0000_0008, 6'd1,  1'b0, 64'd0}
      };
      phase_len = '{6'd32, 6'd1, 6'd0, 6'd63, 6'd2, 6'd31, 6'd33, 6'd3};

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[n]) begin
         if (directed_rows[n].set_len) begin
            write_length(directed_rows[n].len);
         end else begin
            for (int j = 0; j < directed_rows[n].reps; j++)
               send_char(directed_rows[n].ch, directed_rows[n].first && (j == 0),
                         directed_rows[n].id, directed_rows[n].typed, directed_rows[n].kmer);
         end
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         len = (phase < 8) ? phase_len[phase] : LEN_W'($urandom_range(0, 63));
         write_length(len);
         k = active_k(len);
         no_idle = (phase % 4 == 2);
         if (phase == 4)
            hold_off_cycles = LONG_HOLD;
         sent = 0;
         seq_idx = 0;
         while (sent < PHASE_ITEMS) begin
            if ($urandom_range(0, 9) == 0)
               seq_len = $urandom_range(1, k);
            else
               seq_len = k + $urandom_range(0, 24);
            case ($urandom_range(0, 9))
               0: id = '0;
               1: id = '1;
               default: id = $urandom;
            endcase
            for (int i = 0; i < seq_len && sent < PHASE_ITEMS; i++) begin
               r = $urandom_range(0, 99);
               if (r < 2) begin
                  ch = $urandom_range(0, 255);
               end else begin
                  case ($urandom_range(0, 3))
                     0: ch = "A";
                     1: ch = "C";
                     2: ch = "G";
                     default: ch = "T";
                  endcase
                  if ($urandom_range(0, 1))
                     ch = ch | 8'h20;
               end
               // first sequence of a phase leans on the clear from the length write
               if (i == 0)
                  first = (seq_idx != 0) && ($urandom_range(0, 19) != 0);
               else
                  first = ($urandom_range(0, 99) == 0);
               send_char(ch, first, id, 1'b0, '0);
               sent++;
            end
            seq_idx++;
         end
      end

      req_chan.valid <= 1'b0;
      while (pending_kmers.size() != 0) @(negedge clock);
      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

endmodule
